>>> src/fpas_pkg.sv
`default_nettype none
package fpas_pkg;

  localparam int FracBits = 16;
  localparam int DivSteps = 64 + FracBits;
  localparam int MulQBits = 128 - FracBits;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_SUB     = 3'd1,
    CMD_MUL     = 3'd2,
    CMD_DIV     = 3'd3,
    CMD_MOD     = 3'd4,
    CMD_FROM_INT = 3'd5,
    CMD_TO_INT  = 3'd6,
    CMD_RSVD    = 3'd7
  } cmd_t;

  localparam logic [63:0] ValNan    = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ValPinf   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ValNinf   = 64'h8000_0000_0000_0001;
  localparam logic [63:0] FinHigh   = 64'h7FFF_FFFF_FFFF_FFFD;
  localparam logic [63:0] NegMagMax = 64'h7FFF_FFFF_FFFF_FFFE;

  localparam logic signed [64:0] SumHigh = 65'sh0_7FFF_FFFF_FFFF_FFFD;
  localparam logic signed [64:0] SumLow  = 65'sh1_8000_0000_0000_0002;

  localparam logic [63:0] IntSpan = 64'd1 << (63 - FracBits);
  localparam logic signed [63:0] FromIntHigh = signed'(IntSpan - 64'd3);
  localparam logic signed [63:0] FromIntLow  = signed'(64'd2 - IntSpan);
  localparam logic [63:0] ToIntMax = IntSpan - 64'd1;
  localparam logic [63:0] ToIntMin = 64'd0 - IntSpan;

  // One request as it moves down the divider chain.
  typedef struct packed {
    cmd_t                cmd;
    logic                fin;   // res already holds the answer
    logic                neg;   // operand signs differ
    logic                amsb;  // first operand is negative
    logic [63:0]         res;
    logic [63:0]         rem;
    logic [DivSteps-1:0] num;   // dividend bits in, quotient bits out
    logic [63:0]         d;     // divisor magnitude
  } pipe_t;

  // Sign and magnitude to a saturated 64-bit result.
  function automatic logic [63:0] sat_mag(input logic neg, input logic hi_nz,
                                          input logic [63:0] lo);
    logic [63:0] r;
    if (!neg) begin
      r = (hi_nz || (lo > FinHigh)) ? ValPinf : lo;
    end else begin
      r = (hi_nz || (lo > NegMagMax)) ? ValNinf : (64'd0 - lo);
    end
    return r;
  endfunction

  // One restoring division step: shift in a dividend bit, try the subtract.
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t       q;
    logic [64:0] sh;
    logic [65:0] df;
    q  = p;
    sh = {p.rem, p.num[DivSteps-1]};
    df = {1'b0, sh} - {2'b00, p.d};
    q.rem = df[65] ? sh[63:0] : df[63:0];
    q.num = {p.num[DivSteps-2:0], ~df[65]};
    return q;
  endfunction

endpackage
`default_nettype wire

>>> src/fixed_point_alu_with_specials.sv
// Saturating fixed-point ALU, 64-bit operands with 16 fraction bits.
// Input channel: in_tuser carries the command, in_tdata the two operands.
// A request is taken at a rising edge with in_tvalid and in_tready high.
// Output channel: out_tdata carries the 64-bit result; one result per request,
// in request order, taken when out_tvalid and out_tready are both high.
// A request passes from acceptance through the stage-0 register and the
// restoring divider, which retires one quotient bit per stage, to the
// output register. Every command walks the same chain, finished early or not.
// Throughput is one request per cycle while the receiver keeps out_tready high.
// When the receiver stalls, the whole chain holds and in_tready drops in the
// same cycle; nothing is lost or repeated. A waiting result sits in the output
// register while new requests continue to enter whenever that register drains.
// Synchronous reset (rst_n low) empties the chain and clears out_tvalid.
// Special codes: NaN is the most negative value, +inf the largest and -inf
// the most negative plus one; finite results beyond the range saturate to an
// infinity.
`default_nettype none
module fixed_point_alu_with_specials (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // [63:0] operand_a, [127:64] operand_b
  input  wire logic [2:0]   in_tuser,   // [2:0] command
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata   // [63:0] result
);

  localparam int N = fpas_pkg::DivSteps;

  fpas_pkg::pipe_t pipe_r   [0:N];
  fpas_pkg::pipe_t pipe_nxt [0:N];
  fpas_pkg::pipe_t stage0_nxt;
  logic [N:0] vld_r, vld_nxt;

  // Multiplier side path, aligned with stages 1, 2 and 3 of the chain.
  logic [63:0] mpp_r [0:3];
  logic [63:0] mpp_nxt [0:3];
  logic [127:0] mprod_r, mprod_nxt;
  logic [fpas_pkg::MulQBits-1:0] mq_r, mq_nxt;

  logic        out_valid_r;
  logic [63:0] out_data_r, out_nxt;
  logic        adv;

  // The chain moves whenever the output register is empty or being drained.
  assign adv        = !out_valid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  function automatic logic [63:0] sat_sum(input logic signed [64:0] s);
    logic [63:0] r;
    if (s > fpas_pkg::SumHigh) begin
      r = fpas_pkg::ValPinf;
    end else if (s < fpas_pkg::SumLow) begin
      r = fpas_pkg::ValNinf;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  // Stage 0: classify the operands, settle special operands and every command
  // that needs neither multiplier nor divider. Those set fin and ride along.
  always_comb begin
    fpas_pkg::pipe_t s;
    fpas_pkg::cmd_t  cmd;
    logic signed [63:0] a, b;
    logic [63:0] x, y;
    logic a_nan, b_nan, a_inf, b_inf, a_pinf, a_ninf, b_pinf, b_ninf;
    logic a_zero, b_zero, any_nan;
    logic signed [64:0] sum, diff;
    cmd    = fpas_pkg::cmd_t'(in_tuser);
    a      = signed'(in_tdata[63:0]);
    b      = signed'(in_tdata[127:64]);
    x      = a[63] ? (64'd0 - a) : a;
    y      = b[63] ? (64'd0 - b) : b;
    a_nan  = (a == fpas_pkg::ValNan);
    b_nan  = (b == fpas_pkg::ValNan);
    a_pinf = (a == fpas_pkg::ValPinf);
    a_ninf = (a == fpas_pkg::ValNinf);
    b_pinf = (b == fpas_pkg::ValPinf);
    b_ninf = (b == fpas_pkg::ValNinf);
    a_inf  = a_pinf || a_ninf;
    b_inf  = b_pinf || b_ninf;
    a_zero = (a == 64'sd0);
    b_zero = (b == 64'sd0);
    any_nan = a_nan || b_nan;
    sum    = {a[63], a} + {b[63], b};
    diff   = {a[63], a} - {b[63], b};

    s.cmd  = cmd;
    s.fin  = 1'b1;
    s.neg  = a[63] ^ b[63];
    s.amsb = a[63];
    s.res  = fpas_pkg::ValNan;
    s.rem  = 64'd0;
    s.num  = (cmd == fpas_pkg::CMD_MOD) ? {{fpas_pkg::FracBits{1'b0}}, x}
                                        : {x, {fpas_pkg::FracBits{1'b0}}};
    s.d    = y;

    case (cmd)
      fpas_pkg::CMD_ADD: begin
        if (any_nan) begin
          s.res = fpas_pkg::ValNan;
        end else if (a_inf || b_inf) begin
          if ((a_pinf && b_ninf) || (a_ninf && b_pinf)) begin
            s.res = fpas_pkg::ValNan;
          end else begin
            s.res = a_inf ? a : b;
          end
        end else begin
          s.res = sat_sum(sum);
        end
      end
      fpas_pkg::CMD_SUB: begin
        if (any_nan) begin
          s.res = fpas_pkg::ValNan;
        end else if (b_pinf) begin
          s.res = a_pinf ? fpas_pkg::ValNan : fpas_pkg::ValNinf;
        end else if (b_ninf) begin
          s.res = a_ninf ? fpas_pkg::ValNan : fpas_pkg::ValPinf;
        end else if (a_inf) begin
          s.res = a;
        end else begin
          s.res = sat_sum(diff);
        end
      end
      fpas_pkg::CMD_MUL: begin
        if (any_nan) begin
          s.res = fpas_pkg::ValNan;
        end else if (a_inf || b_inf) begin
          if (a_zero || b_zero) begin
            s.res = fpas_pkg::ValNan;
          end else begin
            s.res = (a[63] ^ b[63]) ? fpas_pkg::ValNinf : fpas_pkg::ValPinf;
          end
        end else begin
          s.fin = 1'b0;
        end
      end
      fpas_pkg::CMD_DIV: begin
        if (any_nan) begin
          s.res = fpas_pkg::ValNan;
        end else if (b_zero) begin
          if (a_zero) begin
            s.res = fpas_pkg::ValNan;
          end else begin
            s.res = a[63] ? fpas_pkg::ValNinf : fpas_pkg::ValPinf;
          end
        end else if (a_inf && b_inf) begin
          s.res = fpas_pkg::ValNan;
        end else if (a_inf) begin
          s.res = (a[63] ^ b[63]) ? fpas_pkg::ValNinf : fpas_pkg::ValPinf;
        end else if (b_inf) begin
          s.res = 64'd0;
        end else begin
          s.fin = 1'b0;
        end
      end
      fpas_pkg::CMD_MOD: begin
        if (any_nan || b_zero || a_inf) begin
          s.res = fpas_pkg::ValNan;
        end else if (b_inf) begin
          s.res = a;
        end else begin
          s.fin = 1'b0;
        end
      end
      fpas_pkg::CMD_FROM_INT: begin
        if (a > fpas_pkg::FromIntHigh) begin
          s.res = fpas_pkg::ValPinf;
        end else if (a < fpas_pkg::FromIntLow) begin
          s.res = fpas_pkg::ValNinf;
        end else begin
          s.res = a << fpas_pkg::FracBits;
        end
      end
      fpas_pkg::CMD_TO_INT: begin
        if (a_nan) begin
          s.res = 64'd0;
        end else if (a_pinf) begin
          s.res = fpas_pkg::ToIntMax;
        end else if (a_ninf) begin
          s.res = fpas_pkg::ToIntMin;
        end else if (a[63]) begin
          s.res = 64'd0 - (x >> fpas_pkg::FracBits);
        end else begin
          s.res = x >> fpas_pkg::FracBits;
        end
      end
      default: begin
        s.res = fpas_pkg::ValNan;
      end
    endcase
    stage0_nxt = s;
  end

  // Divider chain: each stage retires one quotient bit. For a remainder
  // request the dividend enters unshifted and only the remainder is used.
  always_comb begin
    pipe_nxt[0] = stage0_nxt;
    for (int k = 1; k <= N; k++) begin
      pipe_nxt[k] = fpas_pkg::div_step(pipe_r[k-1]);
    end
    // The multiplier result joins the chain on its way into stage 4.
    if (pipe_r[3].cmd == fpas_pkg::CMD_MUL && !pipe_r[3].fin) begin
      pipe_nxt[4].res = fpas_pkg::sat_mag(pipe_r[3].neg,
                                          |mq_r[fpas_pkg::MulQBits-1:64], mq_r[63:0]);
      pipe_nxt[4].fin = 1'b1;
    end
  end

  assign vld_nxt = {vld_r[N-1:0], in_tvalid};

  // Multiplier: four 32x32 partial products, then the 128-bit sum, then the
  // fraction shift with rounding toward minus infinity for negative products.
  always_comb begin
    logic [63:0] mx, my;
    mx = pipe_r[0].num[N-1:fpas_pkg::FracBits];
    my = pipe_r[0].d;
    mpp_nxt[0] = 64'(mx[31:0])  * 64'(my[31:0]);
    mpp_nxt[1] = 64'(mx[31:0])  * 64'(my[63:32]);
    mpp_nxt[2] = 64'(mx[63:32]) * 64'(my[31:0]);
    mpp_nxt[3] = 64'(mx[63:32]) * 64'(my[63:32]);
    mprod_nxt  = {mpp_r[3], mpp_r[0]} + {32'd0, mpp_r[1], 32'd0}
               + {32'd0, mpp_r[2], 32'd0};
    mq_nxt     = mprod_r[127:fpas_pkg::FracBits]
               + fpas_pkg::MulQBits'(pipe_r[2].neg & (|mprod_r[fpas_pkg::FracBits-1:0]));
  end

  // Last stage: pass a settled result, saturate a quotient, sign a remainder.
  always_comb begin
    fpas_pkg::pipe_t p;
    p = pipe_r[N];
    if (p.fin) begin
      out_nxt = p.res;
    end else if (p.cmd == fpas_pkg::CMD_DIV) begin
      out_nxt = fpas_pkg::sat_mag(p.neg, |p.num[N-1:64], p.num[63:0]);
    end else if (p.cmd == fpas_pkg::CMD_MOD) begin
      out_nxt = p.amsb ? (64'd0 - p.rem) : p.rem;
    end else begin
      out_nxt = p.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= N; k++) begin
        pipe_r[k] <= pipe_nxt[k];
      end
      for (int j = 0; j < 4; j++) begin
        mpp_r[j] <= mpp_nxt[j];
      end
      mprod_r    <= mprod_nxt;
      mq_r       <= mq_nxt;
      out_data_r <= out_nxt;
    end
  end

  // Reset empties the output register on the following edge.
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  // Only divide and remainder requests may reach the end unresolved.
  a_fin_end: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[N] && !pipe_r[N].fin) |->
      (pipe_r[N].cmd == fpas_pkg::CMD_DIV || pipe_r[N].cmd == fpas_pkg::CMD_MOD))
    else $error("unresolved request at end of chain");

  // A finished division leaves a remainder below the divisor.
  a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[N] && !pipe_r[N].fin) |-> (pipe_r[N].rem < pipe_r[N].d))
    else $error("divider remainder not reduced");

endmodule
`default_nettype wire

>>> dv/tb_fixed_point_alu_with_specials.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_fixed_point_alu_with_specials;

  // The fraction width here must match the block's package constant.
  localparam int FB = fpas_pkg::FracBits;
  localparam int LATENCY = 64 + FB + 2;
  localparam int RANDOM_ITEMS = 400;
  localparam longint CYCLE_LIMIT = 400000;

  // Special codes and the finite range, restated in the bench's own terms.
  localparam logic signed [63:0] QNAN  = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] QPINF = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] QNINF = 64'sh8000_0000_0000_0001;
  localparam logic signed [63:0] QHIGH = 64'sh7FFF_FFFF_FFFF_FFFD;
  localparam logic signed [63:0] QLOW  = 64'sh8000_0000_0000_0002;
  localparam logic signed [63:0] ONE   = 64'sd1 <<< FB;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // [63:0] operand_a, [127:64] operand_b
  logic [2:0]   in_tuser = '0;   // [2:0] command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;       // [63:0] result

  always #2 clk = ~clk;

  fixed_point_alu_with_specials i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // A request: the command, both operands, and an optional result typed in by hand.
  typedef struct {
    fpas_pkg::cmd_t     cmd;
    logic signed [63:0] a;
    logic signed [63:0] b;
    bit                 fixed;
    logic signed [63:0] want;
  } alu_req_t;

  logic signed [63:0] result_queue[$];
  int    mismatch_count = 0;
  int    result_count = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  longint cycle_count = 0;

  function automatic bit is_special(logic signed [63:0] v);
    return v == QNAN || v == QPINF || v == QNINF;
  endfunction

  // Exact signed value in 130 bits folded into the saturated 64-bit range.
  function automatic logic signed [63:0] clamp_wide(logic signed [129:0] v);
    if (v > 130'(QHIGH)) return QPINF;
    if (v < 130'(QLOW)) return QNINF;
    return v[63:0];
  endfunction

  function automatic logic signed [63:0] alu_sum(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    if (a == QNAN || b == QNAN) return QNAN;
    if (is_special(a) || is_special(b)) begin
      if ((a == QPINF && b == QNINF) || (a == QNINF && b == QPINF)) return QNAN;
      return is_special(a) ? a : b;
    end
    return clamp_wide(130'(a) + 130'(b));
  endfunction

  // Computes the expected output of one request.
  function automatic logic signed [63:0] alu_result(fpas_pkg::cmd_t cmd,
                                                    logic signed [63:0] a,
                                                    logic signed [63:0] b);
    logic signed [129:0] wa, wb, q, r;
    logic signed [63:0]  span;
    wa = 130'(a);
    wb = 130'(b);
    span = 64'sd1 <<< (63 - FB);
    case (cmd)
      fpas_pkg::CMD_ADD: return alu_sum(a, b);
      fpas_pkg::CMD_SUB: begin
        if (a == QNAN || b == QNAN) return QNAN;
        if (b == QPINF) return alu_sum(a, QNINF);
        if (b == QNINF) return alu_sum(a, QPINF);
        return is_special(a) ? a : clamp_wide(wa - wb);
      end
      fpas_pkg::CMD_MUL: begin
        if (a == QNAN || b == QNAN) return QNAN;
        if (is_special(a) || is_special(b)) begin
          if (a == 0 || b == 0) return QNAN;
          return ((a < 0) != (b < 0)) ? QNINF : QPINF;
        end
        // Arithmetic shift rounds toward minus infinity, as the block does.
        return clamp_wide((wa * wb) >>> FB);
      end
      fpas_pkg::CMD_DIV: begin
        if (a == QNAN || b == QNAN) return QNAN;
        if (b == 0) return (a == 0) ? QNAN : ((a > 0) ? QPINF : QNINF);
        if (is_special(a) && is_special(b)) return QNAN;
        if (is_special(a)) return ((a > 0) == (b > 0)) ? QPINF : QNINF;
        if (is_special(b)) return 0;
        // Signed division truncates toward zero.
        q = (wa <<< FB) / wb;
        return clamp_wide(q);
      end
      fpas_pkg::CMD_MOD: begin
        if (a == QNAN || b == QNAN || b == 0 || is_special(a)) return QNAN;
        if (is_special(b)) return a;
        r = wa % wb;
        return r[63:0];
      end
      fpas_pkg::CMD_FROM_INT: begin
        if (a > span - 3) return QPINF;
        if (a < 64'sd2 - span) return QNINF;
        return a <<< FB;
      end
      fpas_pkg::CMD_TO_INT: begin
        if (a == QNAN) return 0;
        if (a == QPINF) return span - 1;
        if (a == QNINF) return -span;
        q = wa / (130'sd1 <<< FB);
        return q[63:0];
      end
      default: return QNAN;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
             result_count);
  endtask

  // The receiving side: stall at random, check each result in order.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, '0);
        end else begin
          if (out_tdata !== result_queue[0]) begin
            report_mismatch("result", out_tdata, result_queue[0]);
          end
          void'(result_queue.pop_front());
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Drives one request and waits for it to be taken, with random idle gaps.
  // in_tvalid stays high between back-to-back requests and drops only for a gap.
  task automatic send_request(alu_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req.cmd;
    in_tdata  <= {req.b, req.a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // The request is taken at this edge; predict its result now.
    if (req.fixed) begin
      if (alu_result(req.cmd, req.a, req.b) !== req.want) begin
        report_mismatch("hand-typed result disagrees with predictor",
                        alu_result(req.cmd, req.a, req.b), req.want);
      end
      result_queue.push_back(req.want);
    end else begin
      result_queue.push_back(alu_result(req.cmd, req.a, req.b));
    end
  endtask

  // Random operands lean on the edges: specials, zero, small values, full range.
  function automatic logic signed [63:0] pick_operand();
    case ($urandom_range(9))
      0: return QNAN;
      1: return QPINF;
      2: return QNINF;
      3: return 0;
      4: return $signed(64'($urandom_range(7)) - 64'sd3) <<< FB;
      5: return $signed({{32{1'b0}}, 32'($urandom())}) - 64'sh8000_0000;
      6: return $urandom_range(1) ? QHIGH - $urandom_range(3) : QLOW + $urandom_range(3);
      default: return $signed({32'($urandom()), 32'($urandom())});
    endcase
  endfunction

  alu_req_t directed[$];
  alu_req_t req;
  int phase;

  // Directed rows: extremes and special cases for every command.
  function automatic alu_req_t row(fpas_pkg::cmd_t c, logic signed [63:0] a,
                                   logic signed [63:0] b,
                                   bit fixed = 0, logic signed [63:0] want = 0);
    alu_req_t r;
    r.cmd = c; r.a = a; r.b = b; r.fixed = fixed; r.want = want;
    return r;
  endfunction

  initial begin
    directed = '{
      row(fpas_pkg::CMD_ADD, ONE, ONE, 1, 2 * ONE),
      row(fpas_pkg::CMD_ADD, QHIGH, 1, 1, QPINF),
      row(fpas_pkg::CMD_ADD, QLOW, -1, 1, QNINF),
      row(fpas_pkg::CMD_ADD, QPINF, QNINF, 1, QNAN),
      row(fpas_pkg::CMD_SUB, QPINF, QPINF, 1, QNAN),
      row(fpas_pkg::CMD_SUB, QNAN, 0, 1, QNAN),
      row(fpas_pkg::CMD_SUB, 5, QNINF, 1, QPINF),
      row(fpas_pkg::CMD_MUL, QPINF, 0, 1, QNAN),
      row(fpas_pkg::CMD_MUL, QNINF, -ONE, 1, QPINF),
      row(fpas_pkg::CMD_MUL, -1, 1),
      row(fpas_pkg::CMD_MUL, QHIGH, QHIGH, 1, QPINF),
      row(fpas_pkg::CMD_DIV, 0, 0, 1, QNAN),
      row(fpas_pkg::CMD_DIV, -ONE, 0, 1, QNINF),
      row(fpas_pkg::CMD_DIV, QPINF, QNINF, 1, QNAN),
      row(fpas_pkg::CMD_DIV, QNINF, -3, 1, QPINF),
      row(fpas_pkg::CMD_DIV, 7, QPINF, 1, 0),
      row(fpas_pkg::CMD_DIV, -7 * ONE, 2 * ONE),
      row(fpas_pkg::CMD_MOD, 7, 0, 1, QNAN),
      row(fpas_pkg::CMD_MOD, QPINF, 3, 1, QNAN),
      row(fpas_pkg::CMD_MOD, -9, QPINF, 1, -9),
      row(fpas_pkg::CMD_MOD, -7, 3, 1, -1),
      row(fpas_pkg::CMD_FROM_INT, QHIGH, 0, 1, QPINF),
      row(fpas_pkg::CMD_FROM_INT, QLOW, 0, 1, QNINF),
      row(fpas_pkg::CMD_TO_INT, QNAN, 0, 1, 0),
      row(fpas_pkg::CMD_TO_INT, -ONE - 1, 0, 1, -1),
      row(fpas_pkg::CMD_RSVD, 1, 1, 1, QNAN)
    };
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);

    // Four idling phases; random requests are split among them.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (RANDOM_ITEMS / 4) begin
        req = row(fpas_pkg::cmd_t'($urandom_range(7)), pick_operand(), pick_operand());
        // Integer-to-fixed conversions now and then get integers near the limits.
        if (req.cmd == fpas_pkg::CMD_FROM_INT && $urandom_range(1))
          req.a = (64'sd1 <<< (63 - FB)) - 64'($urandom_range(5)) -
                  ($urandom_range(1) ? (64'sd1 <<< (64 - FB)) : 0);
        send_request(req);
      end
    end
    in_tvalid <= 1'b0;

    while (result_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d directed and %0d random requests over all commands,",
             directed.size(), RANDOM_ITEMS);
    $display("with special operands and sender and receiver idling; %0d results checked.",
             result_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Safety net against a hung handshake.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout with %0d results still expected.", result_queue.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
`default_nettype wire
